FILE: hdl/clg_pkg.sv
// Shared constants, command/status types and helpers for the Coleman-Liau grader.
`timescale 1ns / 1ps

package clg_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int FIELD_WIDTH = 16;
   // 2960 < 2**12, so each scaled count fits COUNT_WIDTH + 12 bits
   localparam int PROD_WIDTH  = COUNT_WIDTH + 12;
   // signed numerator, and room for the shifted divisor in the divider
   localparam int NUM_WIDTH   = COUNT_WIDTH + 14;
   localparam int QUOT_BITS   = 5;
   localparam int STEP_WIDTH  = $clog2(QUOT_BITS);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [FIELD_WIDTH-1:0] FIELD_MAX = '1;

   localparam int COEF_LETTER   = 588;
   localparam int COEF_SENTENCE = 2960;
   localparam int COEF_WORD     = 1580;
   localparam int COEF_DEN      = 100;

   localparam logic [1:0] CLASS_LOW  = 2'd0;
   localparam logic [1:0] CLASS_MID  = 2'd1;
   localparam logic [1:0] CLASS_HIGH = 2'd2;

   localparam logic [4:0] GRADE_MAX = 5'd16;

   typedef struct packed {
      logic count_en;
      logic load_prod;
      logic load_num;
      logic load_div;
      logic ovf_check;
      logic div_step;
      logic out_load;
   } clg_cmd_type;

   typedef struct packed {
      logic out_free;
   } clg_status_type;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
   endfunction

   function automatic logic [FIELD_WIDTH-1:0] clamp_field(input logic [COUNT_WIDTH-1:0] v);
      logic [31:0] wide;
      wide = 32'(v);
      return (wide > 32'(FIELD_MAX)) ? FIELD_MAX : wide[FIELD_WIDTH-1:0];
   endfunction

endpackage

FILE: hdl/clg_if.sv
// Valid/ready channel interfaces for text input and grade results.
`timescale 1ns / 1ps

interface clg_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       last_byte;

   modport source (output valid, output text_byte, output last_byte, input ready);
   modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface clg_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  grade_class;
   logic [4:0]  grade;
   logic [15:0] letter_total;
   logic [15:0] word_total;
   logic [15:0] sentence_total;

   modport source (output valid, output grade_class, output grade, output letter_total,
                   output word_total, output sentence_total, input ready);
   modport sink   (input valid, input grade_class, input grade, input letter_total,
                   input word_total, input sentence_total, output ready);
endinterface

FILE: hdl/coleman_liau_text_grader_unit.sv
// Top level of the Coleman-Liau readability grader.
//
//  channel   dir  modport  beat contents
//  req_bus   in   sink     text_byte[7:0], last_byte
//  rsp_bus   out  source   grade_class[1:0], grade[4:0], letter/word/sentence totals
//
// Bytes without the last flag are taken one per cycle.
// A last byte starts the index sequence: multiply, subtract, prepare, range
// check and 5 divider steps, then the result load, all with req_ready low;
// a stalled rsp beat holds the sequence in the load step.
// A waiting result does not block the next text: the result register parts them.
// Reset is synchronous, active high; it clears counters, sequencer and rsp valid.
`timescale 1ns / 1ps

module coleman_liau_text_grader_unit import clg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   clg_req_if.sink   req_bus,
   clg_rsp_if.source rsp_bus
);

   clg_cmd_type    cmd;
   clg_status_type status;
   logic           ctl_ready;

   assign req_bus.ready = ctl_ready;

   // sequencer
   clg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_last  (req_bus.last_byte),
      .req_ready (ctl_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // counters, arithmetic and result register
   clg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .text_byte (req_bus.text_byte),
      .rsp       (rsp_bus)
   );

   // the last byte always takes the block off the input side
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.last_byte) |=> !req_bus.ready)
      else $error("input accepted during index computation");

   a_mid_grade: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.grade_class == CLASS_MID) |->
         (rsp_bus.grade != 5'd0 && rsp_bus.grade <= GRADE_MAX))
      else $error("grade out of range for middle class");

   a_low_grade: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.grade_class == CLASS_LOW) |-> rsp_bus.grade == 5'd0)
      else $error("nonzero grade in low class");

   a_words: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.word_total != 16'd0)
      else $error("word total of zero");

endmodule

FILE: hdl/clg_ctrl.sv
// Sequencer: counting phase, then the end-of-text index computation.
`timescale 1ns / 1ps

module clg_ctrl import clg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_last,
   output logic           req_ready,
   output clg_cmd_type    cmd,
   input  clg_status_type status
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_SUB  = 3'd2;
   localparam logic [2:0] ST_PREP = 3'd3;
   localparam logic [2:0] ST_OVF  = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic                  accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.count_en = accept;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_last) state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.load_prod = 1'b1;
            state_in      = ST_SUB;
         end
         ST_SUB: begin
            cmd.load_num = 1'b1;
            state_in     = ST_PREP;
         end
         ST_PREP: begin
            cmd.load_div = 1'b1;
            state_in     = ST_OVF;
         end
         ST_OVF: begin
            cmd.ovf_check = 1'b1;
            step_in       = '0;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_WIDTH'(QUOT_BITS - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

FILE: hdl/clg_datapath.sv
// Counters, scaled sums, restoring divider and result register.
`timescale 1ns / 1ps

module clg_datapath import clg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  clg_cmd_type    cmd,
   output clg_status_type status,
   input  logic [7:0]     text_byte,
   clg_rsp_if.source      rsp
);

   logic [COUNT_WIDTH-1:0] letter_ff, letter_in;
   logic [COUNT_WIDTH-1:0] space_ff, space_in;
   logic [COUNT_WIDTH-1:0] sentence_ff, sentence_in;
   logic [COUNT_WIDTH-1:0] words_ff;
   logic [PROD_WIDTH-1:0]  p_letter_ff, p_sentence_ff, p_word_ff, den_ff;
   logic signed [NUM_WIDTH-1:0] num_ff;
   logic [NUM_WIDTH-1:0]   rem_ff, dsh_ff;
   logic [QUOT_BITS-1:0]   quot_ff;
   logic                   neg_ff, ovf_ff;
   logic                   valid_ff;
   logic [1:0]             class_ff, class_in;
   logic [4:0]             grade_ff, grade_in;
   logic [FIELD_WIDTH-1:0] letter_tot_ff, word_tot_ff, sentence_tot_ff;
   logic                   is_letter, is_space, is_mark, fits;

   assign is_letter = text_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   assign is_space  = text_byte inside {8'h20, [8'h09:8'h0D]};
   assign is_mark   = text_byte inside {8'h21, 8'h2E, 8'h3F};

   // classes are exclusive, so at most one counter moves per beat
   always_comb begin
      letter_in   = letter_ff;
      space_in    = space_ff;
      sentence_in = sentence_ff;
      if (cmd.out_load) begin
         letter_in   = '0;
         space_in    = '0;
         sentence_in = '0;
      end else if (cmd.count_en) begin
         if (is_letter)     letter_in   = sat_inc(letter_ff);
         else if (is_space) space_in    = sat_inc(space_ff);
         else if (is_mark)  sentence_in = sat_inc(sentence_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         letter_ff   <= '0;
         space_ff    <= '0;
         sentence_ff <= '0;
      end else begin
         letter_ff   <= letter_in;
         space_ff    <= space_in;
         sentence_ff <= sentence_in;
      end
   end

   // constant multiplies, one stage
   always_ff @(posedge clock) begin
      if (cmd.load_prod) begin
         p_letter_ff   <= PROD_WIDTH'(letter_ff) * PROD_WIDTH'(COEF_LETTER);
         p_sentence_ff <= PROD_WIDTH'(sentence_ff) * PROD_WIDTH'(COEF_SENTENCE);
         p_word_ff     <= PROD_WIDTH'(sat_inc(space_ff)) * PROD_WIDTH'(COEF_WORD);
         den_ff        <= PROD_WIDTH'(sat_inc(space_ff)) * PROD_WIDTH'(COEF_DEN);
         words_ff      <= sat_inc(space_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_num) begin
         num_ff <= $signed(NUM_WIDTH'(p_letter_ff)) - $signed(NUM_WIDTH'(p_sentence_ff))
                 - $signed(NUM_WIDTH'(p_word_ff));
      end
   end

   // round half away: q = (2 num + den) / (2 den); a negative index is class 0 anyway
   always_ff @(posedge clock) begin
      if (cmd.load_div) begin
         neg_ff  <= num_ff[NUM_WIDTH-1];
         rem_ff  <= (NUM_WIDTH'($unsigned(num_ff)) << 1) + NUM_WIDTH'(den_ff);
         dsh_ff  <= NUM_WIDTH'(den_ff) << QUOT_BITS;
         quot_ff <= '0;
      end else if (cmd.ovf_check) begin
         ovf_ff <= (rem_ff >= (dsh_ff << 1));
      end else if (cmd.div_step) begin
         if (rem_ff >= dsh_ff) begin
            rem_ff  <= rem_ff - dsh_ff;
            quot_ff <= {quot_ff[QUOT_BITS-2:0], 1'b1};
         end else begin
            quot_ff <= {quot_ff[QUOT_BITS-2:0], 1'b0};
         end
         dsh_ff <= dsh_ff >> 1;
      end
   end

   assign fits = (5'(quot_ff) <= GRADE_MAX);

   always_comb begin
      if (neg_ff || quot_ff == '0) begin
         class_in = CLASS_LOW;
         grade_in = '0;
      end else if (ovf_ff || !fits) begin
         class_in = CLASS_HIGH;
         grade_in = GRADE_MAX;
      end else begin
         class_in = CLASS_MID;
         grade_in = 5'(quot_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         class_ff        <= class_in;
         grade_ff        <= grade_in;
         letter_tot_ff   <= clamp_field(letter_ff);
         word_tot_ff     <= clamp_field(words_ff);
         sentence_tot_ff <= clamp_field(sentence_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset)             valid_ff <= 1'b0;
      else if (cmd.out_load) valid_ff <= 1'b1;
      else if (rsp.ready)    valid_ff <= 1'b0;
   end

   assign status.out_free    = !valid_ff || rsp.ready;
   assign rsp.valid          = valid_ff;
   assign rsp.grade_class    = class_ff;
   assign rsp.grade          = grade_ff;
   assign rsp.letter_total   = letter_tot_ff;
   assign rsp.word_total     = word_tot_ff;
   assign rsp.sentence_total = sentence_tot_ff;

endmodule
